// ===== hdl/tmr16_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer/counter package
// Shared constants, register codes and the result record of the 16-bit
// timer/counter with prescaler, clear-on-compare and fast PWM.
// ----------------------------------------------------------------------------
package tmr16_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int VALUE_WIDTH    = 16;
    localparam int PRESCALE_WIDTH = 10;

    localparam int RATIO_8    = 8;
    localparam int RATIO_64   = 64;
    localparam int RATIO_256  = 256;
    localparam int RATIO_1024 = 1024;

    // operation codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_WRITE_A = 3'd3;
    localparam logic [2:0] OP_WRITE_B = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [2:0] REG_CLOCK_SELECT = 3'd1;
    localparam logic [2:0] REG_OUT_MODE_A   = 3'd2;
    localparam logic [2:0] REG_OUT_MODE_B   = 3'd3;
    localparam logic [2:0] REG_TOP_VALUE    = 3'd4;
    localparam logic [2:0] REG_PRELOAD      = 3'd5;
    localparam logic [2:0] REG_IRQ_ENABLE   = 3'd6;

    // waveform modes
    localparam logic [1:0] WAVE_NORMAL = 2'd0;
    localparam logic [1:0] WAVE_CTC    = 2'd1;
    localparam logic [1:0] WAVE_PWM    = 2'd2;

    // clock selects
    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;

    // pin action codes
    localparam logic [1:0] PIN_OFF    = 2'd0;
    localparam logic [1:0] PIN_TOGGLE = 2'd1;
    localparam logic [1:0] PIN_CLEAR  = 2'd2;
    localparam logic [1:0] PIN_SET    = 2'd3;

    // flag bit positions
    localparam int FLAG_OVF = 0;
    localparam int FLAG_CMA = 1;
    localparam int FLAG_CMB = 2;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] count_value;
        logic                   pin_a;
        logic                   pin_b;
        logic [2:0]             flags;
        logic                   irq_request;
    } t_result;

    function automatic logic [PRESCALE_WIDTH-1:0] divider_mask(input logic [2:0] sel);
        logic [PRESCALE_WIDTH-1:0] m;
        case (sel)
            CS_DIV8:    m = PRESCALE_WIDTH'(RATIO_8 - 1);
            CS_DIV64:   m = PRESCALE_WIDTH'(RATIO_64 - 1);
            CS_DIV256:  m = PRESCALE_WIDTH'(RATIO_256 - 1);
            CS_DIV1024: m = PRESCALE_WIDTH'(RATIO_1024 - 1);
            default:    m = '0;
        endcase
        return m;
    endfunction

    function automatic logic match_pin(input logic cur, input logic [1:0] mode,
                                       input logic pwm);
        logic lvl;
        lvl = cur;
        case (mode)
            PIN_TOGGLE: lvl = pwm ? cur : ~cur;
            PIN_CLEAR:  lvl = 1'b0;
            PIN_SET:    lvl = 1'b1;
            default:    lvl = cur;
        endcase
        return lvl;
    endfunction

    function automatic logic bottom_pin(input logic cur, input logic [1:0] mode);
        logic lvl;
        lvl = cur;
        case (mode)
            PIN_CLEAR: lvl = 1'b1;
            PIN_SET:   lvl = 1'b0;
            default:   lvl = cur;
        endcase
        return lvl;
    endfunction

endpackage

// ===== hdl/tmr16_core.sv =====
// ----------------------------------------------------------------------------
// Timer/counter core
// Holds the configuration and timer state and works out the next state and
// the result of one beat in a single pass.
// ----------------------------------------------------------------------------
module tmr16_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_index,
    input  logic [tmr16_pkg::VALUE_WIDTH-1:0] i_cfg_data,
    input  logic                             i_step,
    input  logic [2:0]                       i_operation,
    input  logic [tmr16_pkg::VALUE_WIDTH-1:0] i_write_value,
    input  logic [2:0]                       i_clear_mask,
    output tmr16_pkg::t_result               o_result
);

    localparam int CW = tmr16_pkg::COUNT_WIDTH;
    localparam int VW = tmr16_pkg::VALUE_WIDTH;
    localparam int PW = tmr16_pkg::PRESCALE_WIDTH;

    logic [1:0]    r_wave_mode;
    logic [2:0]    r_clock_select;
    logic [1:0]    r_out_mode_a;
    logic [1:0]    r_out_mode_b;
    logic [VW-1:0] r_top_value;
    logic [VW-1:0] r_preload;
    logic [2:0]    r_irq_enable;

    logic [CW-1:0] r_counter,   n_counter;
    logic [PW-1:0] r_prescale,  n_prescale;
    logic [VW-1:0] r_compare_a, n_compare_a;
    logic [VW-1:0] r_compare_b, n_compare_b;
    logic [VW-1:0] r_buffer_a,  n_buffer_a;
    logic [VW-1:0] r_buffer_b,  n_buffer_b;
    logic [2:0]    r_flags,     n_flags;
    logic [1:0]    r_levels,    n_levels;

    logic          pwm;
    logic          hit_a;
    logic          hit_b;
    logic          hit_top;
    logic          fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode    <= '0;
            r_clock_select <= '0;
            r_out_mode_a   <= '0;
            r_out_mode_b   <= '0;
            r_top_value    <= '0;
            r_preload      <= '0;
            r_irq_enable   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tmr16_pkg::REG_WAVE_MODE:    r_wave_mode    <= i_cfg_data[1:0];
                tmr16_pkg::REG_CLOCK_SELECT: r_clock_select <= i_cfg_data[2:0];
                tmr16_pkg::REG_OUT_MODE_A:   r_out_mode_a   <= i_cfg_data[1:0];
                tmr16_pkg::REG_OUT_MODE_B:   r_out_mode_b   <= i_cfg_data[1:0];
                tmr16_pkg::REG_TOP_VALUE:    r_top_value    <= i_cfg_data;
                tmr16_pkg::REG_PRELOAD:      r_preload      <= i_cfg_data;
                tmr16_pkg::REG_IRQ_ENABLE:   r_irq_enable   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign pwm     = (r_wave_mode == tmr16_pkg::WAVE_PWM);
    assign hit_a   = (r_counter == CW'(r_compare_a));
    assign hit_b   = (r_counter == CW'(r_compare_b));
    assign hit_top = (r_counter == CW'(r_top_value));

    always_comb begin
        n_counter   = r_counter;
        n_prescale  = r_prescale;
        n_compare_a = r_compare_a;
        n_compare_b = r_compare_b;
        n_buffer_a  = r_buffer_a;
        n_buffer_b  = r_buffer_b;
        n_flags     = r_flags;
        n_levels    = r_levels;
        fire        = 1'b0;

        case (i_operation)
            tmr16_pkg::OP_TICK: begin
                n_prescale = r_prescale + 1'b1;
                fire = (r_clock_select inside {[tmr16_pkg::CS_DIV1:tmr16_pkg::CS_DIV1024]})
                    && ((n_prescale & tmr16_pkg::divider_mask(r_clock_select)) == '0);
                if (fire) begin
                    if (hit_a) begin
                        n_flags[tmr16_pkg::FLAG_CMA] = 1'b1;
                        n_levels[0] = tmr16_pkg::match_pin(n_levels[0], r_out_mode_a, pwm);
                    end
                    if (hit_b) begin
                        n_flags[tmr16_pkg::FLAG_CMB] = 1'b1;
                        n_levels[1] = tmr16_pkg::match_pin(n_levels[1], r_out_mode_b, pwm);
                    end
                    if (pwm) begin
                        if (hit_top) begin
                            n_counter   = '0;
                            n_flags[tmr16_pkg::FLAG_OVF] = 1'b1;
                            n_compare_a = r_buffer_a;
                            n_compare_b = r_buffer_b;
                            n_levels[0] = tmr16_pkg::bottom_pin(n_levels[0], r_out_mode_a);
                            n_levels[1] = tmr16_pkg::bottom_pin(n_levels[1], r_out_mode_b);
                        end else begin
                            n_counter = r_counter + 1'b1;
                        end
                    end else if (r_wave_mode == tmr16_pkg::WAVE_CTC && hit_a) begin
                        n_counter = '0;
                    end else begin
                        if (&r_counter) begin
                            n_flags[tmr16_pkg::FLAG_OVF] = 1'b1;
                        end
                        n_counter = r_counter + 1'b1;
                    end
                end
            end
            tmr16_pkg::OP_RESTART: begin
                n_counter  = (r_wave_mode == tmr16_pkg::WAVE_CTC || pwm) ? '0
                                                                         : CW'(r_preload);
                n_prescale = '0;
                n_levels   = '0;
            end
            tmr16_pkg::OP_CLEAR: begin
                n_flags = r_flags & ~i_clear_mask;
            end
            tmr16_pkg::OP_WRITE_A: begin
                n_buffer_a = i_write_value;
                if (!pwm) begin
                    n_compare_a = i_write_value;
                end
            end
            tmr16_pkg::OP_WRITE_B: begin
                n_buffer_b = i_write_value;
                if (!pwm) begin
                    n_compare_b = i_write_value;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_prescale  <= '0;
            r_compare_a <= '0;
            r_compare_b <= '0;
            r_buffer_a  <= '0;
            r_buffer_b  <= '0;
            r_flags     <= '0;
            r_levels    <= '0;
        end else if (i_step) begin
            r_counter   <= n_counter;
            r_prescale  <= n_prescale;
            r_compare_a <= n_compare_a;
            r_compare_b <= n_compare_b;
            r_buffer_a  <= n_buffer_a;
            r_buffer_b  <= n_buffer_b;
            r_flags     <= n_flags;
            r_levels    <= n_levels;
        end
    end

    always_comb begin
        o_result.count_value = VW'(n_counter);
        o_result.pin_a       = n_levels[0];
        o_result.pin_b       = n_levels[1];
        o_result.flags       = n_flags;
        o_result.irq_request = |(n_flags & r_irq_enable);
    end

endmodule

// ===== hdl/timer_counter_16bit_pwm.sv =====
// ----------------------------------------------------------------------------
// 16-bit timer/counter with fast PWM
// Timer with prescaler, normal, clear-on-compare and fast PWM modes, two
// compare outputs, status flags and an interrupt request.
// ----------------------------------------------------------------------------
// Every beat (tick, restart, flag clear, compare write or a reserved code)
// gives exactly one result beat, which is registered and shown on the
// output channel the cycle after acceptance. A new beat is taken in every
// cycle while the result register is empty or being drained in the same
// cycle; the rate is one beat per cycle, set by the single-pass next-state
// logic of the core. Configuration writes take effect on the next beat and
// are meant for times when no beat is in flight.
module timer_counter_16bit_pwm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_write_value,
    input  logic [2:0]  i_clear_mask,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_count_value,
    output logic        o_pin_a,
    output logic        o_pin_b,
    output logic [2:0]  o_flags,
    output logic        o_irq_request
);

    logic                 accept;
    logic                 r_out_valid;
    tmr16_pkg::t_result   r_result;
    tmr16_pkg::t_result   core_result;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    tmr16_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_step        (accept),
        .i_operation   (i_operation),
        .i_write_value (i_write_value),
        .i_clear_mask  (i_clear_mask),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_count_value = r_result.count_value;
    assign o_pin_a       = r_result.pin_a;
    assign o_pin_b       = r_result.pin_b;
    assign o_flags       = r_result.flags;
    assign o_irq_request = r_result.irq_request;

    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_irq_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_irq_request) |-> (o_flags != 3'b000))
        else $error("interrupt request without a pending flag");

    a_clear_drops_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == tmr16_pkg::OP_CLEAR)
            |=> ((o_flags & $past(i_clear_mask)) == 3'b000))
        else $error("flag clear left a masked flag set");

    a_restart_drops_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == tmr16_pkg::OP_RESTART) |=> (!o_pin_a && !o_pin_b))
        else $error("restart left a compare pin high");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid) |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

// ===== dv/tb_timer_counter_16bit_pwm.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the 16-bit timer/counter with fast PWM
// Sends ticks, restarts, flag clears, compare writes and reserved codes through
// the valid/ready input channel under a series of register settings, with and
// without idling on either side. A scoreboard predicts every result beat and
// checks each one, field by field, in order at the output channel.
// ----------------------------------------------------------------------------
module tb_timer_counter_16bit_pwm;

    localparam int unsigned CYCLE_LIMIT = 600000;

    localparam logic [2:0]  OP_RSVD_5   = tmr16_pkg::OP_WRITE_B + 3'd1;
    localparam logic [2:0]  OP_RSVD_6   = tmr16_pkg::OP_WRITE_B + 3'd2;
    localparam logic [2:0]  OP_RSVD_7   = tmr16_pkg::OP_WRITE_B + 3'd3;
    localparam logic [1:0]  WAVE_RSVD_3 = tmr16_pkg::WAVE_PWM + 2'd1;
    localparam logic [2:0]  CS_RSVD_6   = tmr16_pkg::CS_DIV1024 + 3'd1;
    localparam logic [2:0]  CS_RSVD_7   = tmr16_pkg::CS_DIV1024 + 3'd2;
    localparam logic [15:0] COUNT_MAX   = '1;

    typedef struct {
        logic [1:0]  wave;
        logic [2:0]  csel;
        logic [1:0]  act_a;
        logic [1:0]  act_b;
        logic [15:0] top;
        logic [15:0] preload;
        logic [2:0]  irq_en;
        int          items;
        logic [15:0] win_lo;
        logic [15:0] win_hi;
        int          tick_pct;
        int          restart_pct;
        bit          lead_restart;
    } t_phase;

    class t_scoreboard;
        bit [1:0]  wave;
        bit [2:0]  csel;
        bit [1:0]  act_a;
        bit [1:0]  act_b;
        bit [15:0] top;
        bit [15:0] preload;
        bit [2:0]  irq_en;

        bit [15:0] count;
        bit [9:0]  prescale;
        bit [15:0] cmp_a;
        bit [15:0] cmp_b;
        bit [15:0] buf_a;
        bit [15:0] buf_b;
        bit [2:0]  flags;
        bit [1:0]  pins;

        tmr16_pkg::t_result timer_results_q[$];
        int                 errors;

        function int pending();
            return timer_results_q.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                tmr16_pkg::REG_WAVE_MODE:    wave    = data[1:0];
                tmr16_pkg::REG_CLOCK_SELECT: csel    = data[2:0];
                tmr16_pkg::REG_OUT_MODE_A:   act_a   = data[1:0];
                tmr16_pkg::REG_OUT_MODE_B:   act_b   = data[1:0];
                tmr16_pkg::REG_TOP_VALUE:    top     = data;
                tmr16_pkg::REG_PRELOAD:      preload = data;
                tmr16_pkg::REG_IRQ_ENABLE:   irq_en  = data[2:0];
                default: ;
            endcase
        endfunction

        function bit match_level(bit lvl, bit [1:0] act, bit pwm);
            case (act)
                tmr16_pkg::PIN_TOGGLE: return pwm ? lvl : ~lvl;
                tmr16_pkg::PIN_CLEAR:  return 1'b0;
                tmr16_pkg::PIN_SET:    return 1'b1;
                default:               return lvl;
            endcase
        endfunction

        function bit bottom_level(bit lvl, bit [1:0] act);
            if (act == tmr16_pkg::PIN_CLEAR)
                return 1'b1;
            if (act == tmr16_pkg::PIN_SET)
                return 1'b0;
            return lvl;
        endfunction

        function bit prescaler_due();
            case (csel)
                tmr16_pkg::CS_DIV1:    return 1'b1;
                tmr16_pkg::CS_DIV8:    return (prescale % tmr16_pkg::RATIO_8) == 0;
                tmr16_pkg::CS_DIV64:   return (prescale % tmr16_pkg::RATIO_64) == 0;
                tmr16_pkg::CS_DIV256:  return (prescale % tmr16_pkg::RATIO_256) == 0;
                tmr16_pkg::CS_DIV1024: return prescale == 0;
                default:               return 1'b0;
            endcase
        endfunction

        // compare and top matches use the count before the increment
        function void advance_count();
            bit [15:0] old;
            bit        pwm;
            old = count;
            pwm = (wave == tmr16_pkg::WAVE_PWM);
            if (old == cmp_a) begin
                flags[tmr16_pkg::FLAG_CMA] = 1'b1;
                pins[0] = match_level(pins[0], act_a, pwm);
            end
            if (old == cmp_b) begin
                flags[tmr16_pkg::FLAG_CMB] = 1'b1;
                pins[1] = match_level(pins[1], act_b, pwm);
            end
            if (pwm) begin
                if (old == top) begin
                    count = '0;
                    flags[tmr16_pkg::FLAG_OVF] = 1'b1;
                    cmp_a = buf_a;
                    cmp_b = buf_b;
                    pins[0] = bottom_level(pins[0], act_a);
                    pins[1] = bottom_level(pins[1], act_b);
                end else begin
                    count = old + 16'd1;
                end
            end else if (wave == tmr16_pkg::WAVE_CTC && old == cmp_a) begin
                count = '0;
            end else begin
                if (old == COUNT_MAX)
                    flags[tmr16_pkg::FLAG_OVF] = 1'b1;
                count = old + 16'd1;
            end
        endfunction

        function void note_input(logic [2:0] op, logic [15:0] val, logic [2:0] clr);
            tmr16_pkg::t_result r;
            case (op)
                tmr16_pkg::OP_TICK: begin
                    prescale = prescale + 10'd1;
                    if (prescaler_due())
                        advance_count();
                end
                tmr16_pkg::OP_RESTART: begin
                    count    = (wave == tmr16_pkg::WAVE_CTC || wave == tmr16_pkg::WAVE_PWM)
                               ? 16'd0 : preload;
                    prescale = '0;
                    pins     = '0;
                end
                tmr16_pkg::OP_CLEAR: flags = flags & ~clr;
                tmr16_pkg::OP_WRITE_A: begin
                    buf_a = val;
                    if (wave != tmr16_pkg::WAVE_PWM)
                        cmp_a = val;
                end
                tmr16_pkg::OP_WRITE_B: begin
                    buf_b = val;
                    if (wave != tmr16_pkg::WAVE_PWM)
                        cmp_b = val;
                end
                default: ;
            endcase
            r.count_value = count;
            r.pin_a       = pins[0];
            r.pin_b       = pins[1];
            r.flags       = flags;
            r.irq_request = |(flags & irq_en);
            timer_results_q.push_back(r);
        endfunction

        function void cmp_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        endfunction

        function void check_result(logic [15:0] cnt, logic pa, logic pb, logic [2:0] fl,
                                   logic irq);
            tmr16_pkg::t_result want;
            if (timer_results_q.size() == 0) begin
                errors++;
                $error("unexpected result beat: count_value 0x%0h", cnt);
                return;
            end
            want = timer_results_q.pop_front();
            cmp_field("count_value", want.count_value, cnt);
            cmp_field("pin_a", 16'(want.pin_a), 16'(pa));
            cmp_field("pin_b", 16'(want.pin_b), 16'(pb));
            cmp_field("flags", 16'(want.flags), 16'(fl));
            cmp_field("irq_request", 16'(want.irq_request), 16'(irq));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_operation;
    logic [15:0] i_write_value;
    logic [2:0]  i_clear_mask;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_count_value;
    logic        o_pin_a;
    logic        o_pin_b;
    logic [2:0]  o_flags;
    logic        o_irq_request;

    t_scoreboard sb = new;
    int send_gap_pct  = 0;
    int out_stall_pct = 0;

    timer_counter_16bit_pwm dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("** timer_counter_16bit_pwm: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_count_value, o_pin_a, o_pin_b, o_flags, o_irq_request);
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // hold valid across beats; drop it only ahead of a gap
    task automatic send_item(input logic [2:0] op, input logic [15:0] val,
                             input logic [2:0] clr);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_write_value <= val;
        i_clear_mask  <= clr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(op, val, clr);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_phase p);
        logic [15:0] vals [tmr16_pkg::REG_WAVE_MODE:tmr16_pkg::REG_IRQ_ENABLE];
        drain();
        vals[tmr16_pkg::REG_WAVE_MODE]    = 16'(p.wave);
        vals[tmr16_pkg::REG_CLOCK_SELECT] = 16'(p.csel);
        vals[tmr16_pkg::REG_OUT_MODE_A]   = 16'(p.act_a);
        vals[tmr16_pkg::REG_OUT_MODE_B]   = 16'(p.act_b);
        vals[tmr16_pkg::REG_TOP_VALUE]    = p.top;
        vals[tmr16_pkg::REG_PRELOAD]      = p.preload;
        vals[tmr16_pkg::REG_IRQ_ENABLE]   = 16'(p.irq_en);
        for (int r = tmr16_pkg::REG_WAVE_MODE; r <= tmr16_pkg::REG_IRQ_ENABLE; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            sb.set_reg(3'(r), vals[r]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_op(int tick_pct, int restart_pct);
        int r;
        int x;
        r = $urandom_range(99);
        x = $urandom_range(99);
        if (r < tick_pct)
            return tmr16_pkg::OP_TICK;
        if (r < tick_pct + restart_pct)
            return tmr16_pkg::OP_RESTART;
        if (x < 35)
            return tmr16_pkg::OP_CLEAR;
        if (x < 65)
            return tmr16_pkg::OP_WRITE_A;
        if (x < 90)
            return tmr16_pkg::OP_WRITE_B;
        return OP_RSVD_5 + 3'($urandom_range(2));
    endfunction

    task automatic run_phase(input t_phase p, input int phase_no);
        logic [2:0]  op;
        logic [15:0] val;
        apply_setting(p);
        case (phase_no % 4)
            0: begin send_gap_pct = 0;  out_stall_pct = 0;  end
            1: begin send_gap_pct = 86; out_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  out_stall_pct = 86; end
            default: begin send_gap_pct = 17; out_stall_pct = 17; end
        endcase
        if (p.lead_restart)
            send_item(tmr16_pkg::OP_RESTART, 16'($urandom), 3'($urandom));
        for (int k = 0; k < p.items; k++) begin
            // hold off until every pending result is back
            if (k == p.items / 2)
                drain();
            op  = pick_op(p.tick_pct, p.restart_pct);
            val = ($urandom_range(3) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(p.win_hi, p.win_lo));
            send_item(op, val, 3'($urandom));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= tmr16_pkg::REG_WAVE_MODE;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_operation   <= tmr16_pkg::OP_TICK;
        i_write_value <= '0;
        i_clear_mask  <= '0;
        i_out_ready   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wrap at maximum, matches at both ends of the range, spare opcodes
        apply_setting('{tmr16_pkg::WAVE_NORMAL, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_TOGGLE,
                        tmr16_pkg::PIN_CLEAR, 16'd0, 16'hFFFE,
                        3'd7, 0, 16'd0, 16'd0, 0, 0, 1'b0});
        send_item(tmr16_pkg::OP_RESTART, 16'h0000, 3'd0);
        send_item(tmr16_pkg::OP_WRITE_A, 16'hFFFF, 3'd0);
        send_item(tmr16_pkg::OP_WRITE_B, 16'h0000, 3'd0);
        send_item(tmr16_pkg::OP_TICK, 16'h0000, 3'd0);
        send_item(tmr16_pkg::OP_TICK, 16'h0000, 3'd0);
        send_item(tmr16_pkg::OP_TICK, 16'h0000, 3'd0);
        send_item(tmr16_pkg::OP_CLEAR, 16'h0000, 3'b001);
        send_item(OP_RSVD_5, 16'hFFFF, 3'b111);
        send_item(OP_RSVD_6, 16'hFFFF, 3'b111);
        send_item(OP_RSVD_7, 16'hFFFF, 3'b111);
        send_item(tmr16_pkg::OP_CLEAR, 16'hFFFF, 3'b110);
        send_item(tmr16_pkg::OP_WRITE_A, 16'hAAAA, 3'd0);
        send_item(tmr16_pkg::OP_WRITE_B, 16'h5555, 3'd0);

        // buffered compare writes, non-inverting and inverting pins around top
        apply_setting('{tmr16_pkg::WAVE_PWM, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_CLEAR,
                        tmr16_pkg::PIN_SET, 16'd2, 16'd0,
                        3'd1, 0, 16'd0, 16'd0, 0, 0, 1'b0});
        send_item(tmr16_pkg::OP_RESTART, 16'h0000, 3'd0);
        send_item(tmr16_pkg::OP_WRITE_A, 16'h0001, 3'd0);
        send_item(tmr16_pkg::OP_WRITE_B, 16'h0002, 3'd0);
        repeat (6) send_item(tmr16_pkg::OP_TICK, 16'h0000, 3'd0);

        run_phase('{tmr16_pkg::WAVE_NORMAL, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_TOGGLE,
                    tmr16_pkg::PIN_CLEAR, 16'd0, 16'd65520,
                    3'd7, 50, 16'd65505, 16'hFFFF, 80, 3, 1'b0}, 0);
        run_phase('{tmr16_pkg::WAVE_PWM, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_CLEAR,
                    tmr16_pkg::PIN_SET, 16'd20, 16'd0,
                    3'd6, 50, 16'd0, 16'd23, 80, 2, 1'b0}, 1);
        run_phase('{tmr16_pkg::WAVE_CTC, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_TOGGLE,
                    tmr16_pkg::PIN_SET, 16'hFFFF, 16'd0,
                    3'd1, 50, 16'd0, 16'd24, 75, 3, 1'b0}, 2);
        run_phase('{tmr16_pkg::WAVE_PWM, tmr16_pkg::CS_DIV8, tmr16_pkg::PIN_SET,
                    tmr16_pkg::PIN_CLEAR, 16'd9, 16'd100,
                    3'd4, 50, 16'd0, 16'd11, 85, 1, 1'b0}, 3);
        run_phase('{tmr16_pkg::WAVE_PWM, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_TOGGLE,
                    tmr16_pkg::PIN_OFF, 16'd0, 16'hFFFF,
                    3'd2, 30, 16'd0, 16'd3, 80, 2, 1'b0}, 4);
        run_phase('{WAVE_RSVD_3, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_SET,
                    tmr16_pkg::PIN_TOGGLE, 16'd100, 16'hFFFF,
                    3'd5, 40, 16'd65525, 16'hFFFF, 80, 4, 1'b0}, 5);
        run_phase('{tmr16_pkg::WAVE_PWM, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_SET,
                    tmr16_pkg::PIN_SET, 16'hFFFF, 16'd0,
                    3'd7, 50, 16'd65500, 16'hFFFF, 85, 0, 1'b0}, 6);
        run_phase('{tmr16_pkg::WAVE_NORMAL, tmr16_pkg::CS_STOP, tmr16_pkg::PIN_TOGGLE,
                    tmr16_pkg::PIN_TOGGLE, 16'd0, 16'd1234,
                    3'd3, 40, 16'd1230, 16'd1240, 80, 3, 1'b0}, 7);
        run_phase('{tmr16_pkg::WAVE_NORMAL, CS_RSVD_6, tmr16_pkg::PIN_CLEAR,
                    tmr16_pkg::PIN_CLEAR, 16'd0, 16'd10,
                    3'd7, 30, 16'd8, 16'd12, 80, 3, 1'b0}, 8);
        run_phase('{tmr16_pkg::WAVE_CTC, CS_RSVD_7, tmr16_pkg::PIN_SET,
                    tmr16_pkg::PIN_SET, 16'd0, 16'd0,
                    3'd7, 30, 16'd0, 16'd3, 80, 3, 1'b0}, 9);
        // slow dividers: past a leading restart, no restarts in these phases so the prescaler can roll over
        run_phase('{tmr16_pkg::WAVE_CTC, tmr16_pkg::CS_DIV64, tmr16_pkg::PIN_CLEAR,
                    tmr16_pkg::PIN_TOGGLE, 16'd0, 16'd0,
                    3'd0, 140, 16'd0, 16'd4, 92, 0, 1'b1}, 10);
        run_phase('{tmr16_pkg::WAVE_PWM, tmr16_pkg::CS_DIV256, tmr16_pkg::PIN_CLEAR,
                    tmr16_pkg::PIN_CLEAR, 16'd3, 16'd0,
                    3'd7, 280, 16'd0, 16'd5, 95, 0, 1'b0}, 11);
        run_phase('{tmr16_pkg::WAVE_NORMAL, tmr16_pkg::CS_DIV1024, tmr16_pkg::PIN_TOGGLE,
                    tmr16_pkg::PIN_TOGGLE, 16'd0, 16'd40000,
                    3'd3, 720, 16'd0, 16'd6, 97, 0, 1'b0}, 12);
        run_phase('{tmr16_pkg::WAVE_NORMAL, tmr16_pkg::CS_DIV1, tmr16_pkg::PIN_CLEAR,
                    tmr16_pkg::PIN_SET, 16'd0, 16'd0,
                    3'd7, 50, 16'd0, 16'd40, 70, 5, 1'b0}, 13);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** timer_counter_16bit_pwm: PASSED **");
        else
            $display("** timer_counter_16bit_pwm: FAILED **");
        $finish;
    end

endmodule
